// File: hw/rtl/circular_deque_unit_assert.svh
// Assertion macros shared by the circular deque RTL.
// Depends on nothing; included by the top level only.
`ifndef CIRCULAR_DEQUE_UNIT_ASSERT_SVH
`define CIRCULAR_DEQUE_UNIT_ASSERT_SVH

// Same-cycle implication, masked while reset is asserted.
`define CDQ_ASSERT_NOW(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define CDQ_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: hw/rtl/cdq_pkg.sv
// Shared types and constants for the circular deque unit.
// No dependencies; imported by cdq_cell and circular_deque_unit.
package cdq_pkg;

    localparam int unsigned DATA_W        = 32;
    localparam int unsigned REQ_W         = 2;
    localparam int unsigned STATUS_W      = 2;
    localparam int unsigned CNT_W         = 7;
    localparam int unsigned DEPTH_DEFAULT = 64;
    localparam int unsigned CAP_MAX       = (1 << CNT_W) - 1;
    localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 2'd0,
        REQ_PUSH_REAR  = 2'd1,
        REQ_POP_FRONT  = 2'd2,
        REQ_POP_REAR   = 2'd3
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic shift_back;   // front push: every word moves one cell rearward
        logic shift_fwd;    // front pop: every word moves one cell frontward
        logic load_rear;    // rear push: the first free cell loads the word
    } cell_cmd_t;

endpackage

// File: hw/rtl/cdq_cell.sv
// One storage cell of the deque chain: holds a word, trades with neighbors.
// Depends on cdq_pkg.
module cdq_cell #(
    parameter int unsigned CMP_W    = 7,
    parameter int unsigned CELL_IDX = 0
) (
    input  logic                             clk,
    input  cdq_pkg::cell_cmd_t               cmd,
    input  logic [cdq_pkg::CNT_W-1:0]        occ,
    input  logic [cdq_pkg::DATA_W-1:0]       push_word,
    input  logic [cdq_pkg::DATA_W-1:0]       prev_word,
    input  logic [cdq_pkg::DATA_W-1:0]       next_word,
    output logic [cdq_pkg::DATA_W-1:0]       word,
    output logic [cdq_pkg::DATA_W-1:0]       tail_tap
);
    import cdq_pkg::*;

    localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(CELL_IDX);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic [CMP_W-1:0]  occ_ext;
    logic              is_free_head;
    logic              is_tail;

    assign occ_ext      = CMP_W'(occ);
    assign is_free_head = (occ_ext == MY_IDX);
    assign is_tail      = (occ != '0) && ((occ_ext - CMP_W'(1)) == MY_IDX);

    always_comb
    begin
        priority if (cmd.shift_back)
        begin
            data_next = prev_word;
        end
        else if (cmd.shift_fwd)
        begin
            data_next = next_word;
        end
        else if (cmd.load_rear && is_free_head)
        begin
            data_next = push_word;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign word     = data_reg;
    assign tail_tap = is_tail ? data_reg : '0;

endmodule

// File: hw/rtl/circular_deque_unit.sv
// Circular deque unit: a double-ended queue of signed 32-bit words that
// takes one request word per cycle while the result channel is not
// stalled (push or pop at either end) and returns one result word per
// request: status, popped word and count after it. Depends on cdq_pkg,
// cdq_cell and circular_deque_unit_assert.svh.
// Usage: each accepted request produces exactly one result word in the
// output register on the next cycle. A new request is taken in the same
// cycle the previous result is taken, so throughput is one word per cycle
// while out_ready does not stall the result; the rate is set by the single
// output register and the cell chain, which finishes any request as it is
// accepted. Storage is a row of DEPTH cells in logical order: the front
// word is always in cell 0 and the rear word in cell count-1. A front push
// shifts the whole row rearward, a front pop shifts it frontward, a rear
// push loads the first free cell and a rear pop reads the last used cell
// through an OR tree of per-cell taps. The capacity register (reset 64)
// limits how many words are held; zero acts as one and values above DEPTH
// act as DEPTH. Writing it empties the queue; write it only while no
// request is in flight. A push into a full queue returns status full, a
// pop from an empty queue returns status empty; both leave the contents
// untouched and return zero data. No clearing pass is needed after reset.
`include "circular_deque_unit_assert.svh"

module circular_deque_unit #(
    parameter int unsigned DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // request channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [cdq_pkg::REQ_W-1:0]           req_type,
    input  logic signed [cdq_pkg::DATA_W-1:0]   value,
    // result channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [cdq_pkg::STATUS_W-1:0]        status,
    output logic signed [cdq_pkg::DATA_W-1:0]   popped_value,
    output logic [cdq_pkg::CNT_W-1:0]           item_count,
    // capacity register
    input  logic                                cfg_write_en,
    input  logic [cdq_pkg::CNT_W-1:0]           cfg_write_data
);
    import cdq_pkg::*;

    localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CMP_W = (IDX_W > CNT_W) ? IDX_W : CNT_W;
    // Largest usable capacity: DEPTH, or what the count field can hold.
    localparam logic [CNT_W-1:0] CAP_LIMIT = CNT_W'((DEPTH < CAP_MAX) ? DEPTH : CAP_MAX);

    // Control state
    logic [CNT_W-1:0] cap_reg;
    logic [CNT_W-1:0] occ_reg;
    logic [CNT_W-1:0] occ_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    // Result payload
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [DATA_W-1:0]   popped_reg;
    logic [DATA_W-1:0]   popped_next;
    logic [CNT_W-1:0]    count_reg;

    logic [CNT_W-1:0]  eff_cap;
    logic              accept;
    logic              is_full;
    logic              is_empty;
    logic              req_ok;
    req_t              req;
    cell_cmd_t         cmd;
    logic [DATA_W-1:0] cell_word [DEPTH];
    logic [DATA_W-1:0] cell_tap  [DEPTH];
    logic [DATA_W-1:0] tail_word;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign req      = req_t'(req_type);

    // Zero capacity acts as one, oversize acts as the row length.
    always_comb
    begin
        priority if (cap_reg == '0)
        begin
            eff_cap = CNT_W'(1);
        end
        else if (cap_reg > CAP_LIMIT)
        begin
            eff_cap = CAP_LIMIT;
        end
        else
        begin
            eff_cap = cap_reg;
        end
    end

    assign is_full  = (occ_reg >= eff_cap);
    assign is_empty = (occ_reg == '0);

    // Rear word: only the tail cell drives a nonzero tap.
    always_comb
    begin
        tail_word = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            tail_word = tail_word | cell_tap[i];
        end
    end

    // Request decode
    always_comb
    begin
        status_next = ST_DONE;
        popped_next = '0;
        occ_next    = occ_reg;
        unique case (req)
            REQ_PUSH_FRONT, REQ_PUSH_REAR:
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    occ_next = occ_reg + CNT_W'(1);
                end
            end
            REQ_POP_FRONT:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    popped_next = cell_word[0];
                    occ_next    = occ_reg - CNT_W'(1);
                end
            end
            REQ_POP_REAR:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    popped_next = tail_word;
                    occ_next    = occ_reg - CNT_W'(1);
                end
            end
            default:
            begin
                status_next = ST_DONE;
            end
        endcase
    end

    assign req_ok         = (status_next == ST_DONE);
    assign cmd.shift_back = accept && req_ok && (req == REQ_PUSH_FRONT);
    assign cmd.shift_fwd  = accept && req_ok && (req == REQ_POP_FRONT);
    assign cmd.load_rear  = accept && req_ok && (req == REQ_PUSH_REAR);

    assign out_valid_next = accept ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    // Cell chain: cell 0 is the front of the queue.
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [DATA_W-1:0] prev_w;
        logic [DATA_W-1:0] next_w;

        if (g == 0)
        begin : g_first
            assign prev_w = value;
        end
        else
        begin : g_mid
            assign prev_w = cell_word[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign next_w = cell_word[g];
        end
        else
        begin : g_inner
            assign next_w = cell_word[g+1];
        end

        cdq_cell #(
            .CMP_W    (CMP_W),
            .CELL_IDX (g)
        ) u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .occ       (occ_reg),
            .push_word (value),
            .prev_word (prev_w),
            .next_word (next_w),
            .word      (cell_word[g]),
            .tail_tap  (cell_tap[g])
        );
    end

    // Control registers; a capacity write empties the queue.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                cap_reg <= cfg_write_data;
                occ_reg <= '0;
            end
            else if (accept)
            begin
                occ_reg <= occ_next;
            end
        end
    end

    // Result word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            popped_reg <= popped_next;
            count_reg  <= occ_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign popped_value = popped_reg;
    assign item_count   = count_reg;

    // Checks
    `CDQ_ASSERT_NOW(a_occ_bound, clk, rst_n, 1'b1, occ_reg <= eff_cap, "count above capacity")
    `CDQ_ASSERT_NEXT(a_pop_empty, clk, rst_n, accept && req_type[1] && is_empty && !cfg_write_en, out_valid && (status == ST_EMPTY) && (item_count == '0), "pop of empty queue not flagged")
    `CDQ_ASSERT_NEXT(a_reject_hold, clk, rst_n, accept && !req_ok && !cfg_write_en, $stable(occ_reg), "rejected request changed count")
    `CDQ_ASSERT_NOW(a_zero_data, clk, rst_n, out_valid && (status != ST_DONE), popped_value == '0, "rejected request returned data")

endmodule
